@@ rtl/mped_pkg.sv @@
// ----------------------------------------------------------------------------
// mped_pkg
// Shared types and constants of the mouse packet event decoder.
// ----------------------------------------------------------------------------
package mped_pkg;

    // status bit that marks an auxiliary (mouse) data byte
    localparam int unsigned AUX_BIT = 5;

    // bytes in one packet, buttons decoded from byte 0
    localparam int unsigned PACKET_LEN   = 3;
    localparam int unsigned BUTTON_COUNT = 3;

    // event kind codes
    localparam logic [1:0] KIND_MOVE = 2'd0;
    localparam logic [1:0] KIND_DOWN = 2'd1;
    localparam logic [1:0] KIND_UP   = 2'd2;

    // decoded packet handed from front to back
    typedef struct packed {
        logic                    move;     // nonzero motion in packet
        logic [7:0]              dx;       // byte 1 as is
        logic [7:0]              ny;       // byte 2 negated, wrapped
        logic [BUTTON_COUNT-1:0] changed;  // buttons that toggled
        logic [BUTTON_COUNT-1:0] buttons;  // new button state
    } t_pkt_desc;

    // one result event
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] dx;
        logic [7:0] dy;
        logic [1:0] button;
        logic       last;
    } t_event;

endpackage

@@ rtl/mped_if.sv @@
// ----------------------------------------------------------------------------
// mped_if
// Valid/ready channels of the mouse packet event decoder.
// ----------------------------------------------------------------------------
interface mped_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] status_byte;
    logic [7:0] data_byte;

    modport source (output valid, output status_byte, output data_byte, input ready);
    modport sink   (input valid, input status_byte, input data_byte, output ready);
endinterface

interface mped_out_if;
    logic              valid;
    logic              ready;
    logic        [1:0] event_kind;
    logic signed [7:0] delta_x;
    logic signed [7:0] delta_y;
    logic        [1:0] button_number;
    logic              last_event;

    modport source (
        output valid, output event_kind, output delta_x, output delta_y,
        output button_number, output last_event, input ready
    );
    modport sink (
        input valid, input event_kind, input delta_x, input delta_y,
        input button_number, input last_event, output ready
    );
endinterface

@@ rtl/mped_front.sv @@
// ----------------------------------------------------------------------------
// mped_front
// Accepts input items, gathers packet bytes and classifies each full packet.
// ----------------------------------------------------------------------------
module mped_front
    import mped_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    mped_in_if.sink      i_in,
    input  logic         i_q_full,
    output logic         o_q_push,
    output t_pkt_desc    o_q_data
);

    localparam logic [1:0] LAST_POS = 2'(PACKET_LEN - 1);

    logic [1:0]              r_pos;
    logic [1:0]              n_pos;
    logic [BUTTON_COUNT-1:0] r_byte0;
    logic [7:0]              r_byte1;
    logic [BUTTON_COUNT-1:0] r_buttons;
    logic [BUTTON_COUNT-1:0] n_buttons;

    logic       accept;
    logic       aux;
    logic       at_last;
    logic [1:0] pos_eff;
    t_pkt_desc  desc;

    assign i_in.ready = !i_q_full;
    assign accept     = i_in.valid && i_in.ready;
    assign aux        = i_in.status_byte[AUX_BIT];
    // position three cannot occur; treated as zero
    assign pos_eff    = (r_pos > LAST_POS) ? 2'd0 : r_pos;
    assign at_last    = (pos_eff == LAST_POS);

    always_comb begin
        desc.dx      = r_byte1;
        desc.ny      = 8'(~i_in.data_byte + 8'd1);
        desc.move    = (r_byte1 != 8'd0) || (i_in.data_byte != 8'd0);
        desc.buttons = r_byte0;
        desc.changed = r_byte0 ^ r_buttons;
    end

    assign o_q_data = desc;
    assign o_q_push = accept && aux && at_last && (desc.move || (desc.changed != '0));

    always_comb begin
        n_pos     = r_pos;
        n_buttons = r_buttons;
        if (accept && aux) begin
            if (at_last) begin
                n_pos     = 2'd0;
                n_buttons = r_byte0;
            end else begin
                n_pos = pos_eff + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= 2'd0;
            r_buttons <= '0;
        end else begin
            r_pos     <= n_pos;
            r_buttons <= n_buttons;
        end
    end

    // packet bytes, no reset needed
    always_ff @(posedge i_clk) begin
        if (accept && aux && !at_last) begin
            if (pos_eff == 2'd0) begin
                r_byte0 <= i_in.data_byte[BUTTON_COUNT-1:0];
            end else begin
                r_byte1 <= i_in.data_byte;
            end
        end
    end

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos != 2'd3)
        else $error("byte position out of range");

endmodule

@@ rtl/mped_queue.sv @@
// ----------------------------------------------------------------------------
// mped_queue
// Small register queue of decoded packets between front and back.
// ----------------------------------------------------------------------------
module mped_queue
    import mped_pkg::*;
#(
    parameter int unsigned DEPTH = 2
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_pkt_desc i_push_data,
    output logic      o_full,
    input  logic      i_pop,
    output t_pkt_desc o_pop_data,
    output logic      o_valid
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(DEPTH);

    t_pkt_desc        r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;

    assign o_full     = (r_cnt == CNT_MAX);
    assign o_valid    = (r_cnt != '0);
    assign o_pop_data = r_mem[r_rd];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wr <= (r_wr == PTR_MAX) ? '0 : r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_MAX) ? '0 : r_rd + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");

endmodule

@@ rtl/mped_back.sv @@
// ----------------------------------------------------------------------------
// mped_back
// Expands packets into move and button events, one per cycle unless stalled.
// ----------------------------------------------------------------------------
module mped_back
    import mped_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_valid,
    input  t_pkt_desc i_q_data,
    output logic      o_q_pop,
    mped_out_if.source o_out
);

    localparam int unsigned PEND_W = BUTTON_COUNT + 1;

    logic                    r_busy;
    logic [PEND_W-1:0]       r_pend;   // bit 0 move, bits above buttons
    logic [7:0]              r_dx;
    logic [7:0]              r_ny;
    logic [BUTTON_COUNT-1:0] r_btn;
    logic                    r_out_valid;
    t_event                  r_out;

    logic              out_load;
    logic              emit;
    logic              last;
    logic [PEND_W-1:0] sel;
    logic [PEND_W-1:0] pend_after;
    t_event            ev;

    assign out_load = !r_out_valid || o_out.ready;
    assign emit     = r_busy && out_load;

    // lowest pending event first: move, then buttons 1 to 3
    always_comb begin
        sel = '0;
        for (int i = PEND_W - 1; i >= 0; i--) begin
            if (r_pend[i]) begin
                sel = '0;
                sel[i] = 1'b1;
            end
        end
    end

    assign pend_after = r_pend & ~sel;
    assign last       = (pend_after == '0);

    always_comb begin
        ev.kind   = KIND_MOVE;
        ev.dx     = 8'd0;
        ev.dy     = 8'd0;
        ev.button = 2'd0;
        ev.last   = last;
        if (sel[0]) begin
            ev.dx = r_dx;
            ev.dy = r_ny;
        end
        for (int b = 0; b < BUTTON_COUNT; b++) begin
            if (sel[b+1]) begin
                ev.kind   = r_btn[b] ? KIND_DOWN : KIND_UP;
                ev.button = 2'(b + 1);
            end
        end
    end

    assign o_q_pop = i_q_valid && (!r_busy || (emit && last));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_pend      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_busy <= 1'b1;
                r_pend <= {i_q_data.changed, i_q_data.move};
            end else if (emit) begin
                r_busy <= !last;
                r_pend <= pend_after;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_dx  <= i_q_data.dx;
            r_ny  <= i_q_data.ny;
            r_btn <= i_q_data.buttons;
        end
        if (emit) begin
            r_out <= ev;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.event_kind    = r_out.kind;
    assign o_out.delta_x       = r_out.dx;
    assign o_out.delta_y       = r_out.dy;
    assign o_out.button_number = r_out.button;
    assign o_out.last_event    = r_out.last;

    a_busy_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_pend != '0))
        else $error("busy with no pending event");

    a_move_no_button: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.kind == KIND_MOVE) |-> (r_out.button == 2'd0))
        else $error("move event carries a button number");

endmodule

@@ rtl/mouse_packet_event_decoder_top.sv @@
// ----------------------------------------------------------------------------
// mouse_packet_event_decoder_top
// Three-byte mouse packet decoder: turns aux data bytes into move and
// button up/down events.
//
//   channel  dir  payload                                          handshake
//   i_in     in   status_byte, data_byte                           valid/ready
//   o_out    out  event_kind, delta_x, delta_y, button_number,     valid/ready
//                 last_event
//
// - an item is taken in any cycle the packet queue has room; a full queue
//   stalls every byte, not only the one that completes a packet
// - each packet yields up to four events, one per cycle from the back end
//   while the receiver takes them; an idle back first pops the packet
// - the output register holds an event while the receiver stalls; the back
//   waits with it and moves on in the cycle the event is taken
// - reset (synchronous, active low) clears the byte position, the button
//   state, the queue and the output valid
// ----------------------------------------------------------------------------
module mouse_packet_event_decoder_top
    import mped_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 2  // decoded packets buffered, 2..16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mped_in_if.sink    i_in,
    mped_out_if.source o_out
);

    // front to queue
    logic      q_push;
    t_pkt_desc q_push_data;
    logic      q_full;

    // queue to back
    logic      q_pop;
    t_pkt_desc q_pop_data;
    logic      q_valid;

    // front end: byte gathering, motion and button-change classification
    mped_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_data (q_push_data)
    );

    // decouples item intake from event draining
    mped_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (q_push_data),
        .o_full      (q_full),
        .i_pop       (q_pop),
        .o_pop_data  (q_pop_data),
        .o_valid     (q_valid)
    );

    // back end: one event per cycle into the output register unless stalled
    mped_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_data  (q_pop_data),
        .o_q_pop   (q_pop),
        .o_out     (o_out)
    );

endmodule

@@ tb/tb_mouse_packet_event_decoder_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_mouse_packet_event_decoder_top
// Drives status/data byte items into the mouse packet decoder, predicts the
// move and button events of each three-byte aux packet in a local decoder,
// and checks every event leaving the block in order, under random idling on
// both channels, a long receiver hold-off and a full drain pause.
// ----------------------------------------------------------------------------
module tb_mouse_packet_event_decoder_top;
    import mped_pkg::*;

    // one byte item as offered on the input channel
    typedef struct {
        logic [7:0] status;
        logic [7:0] data;
        bit         drain_first;  // hold the item back until no event is owed
    } t_byte_item;

    logic i_clk;
    logic i_rst_n;

    mped_in_if  in_ch ();
    mped_out_if out_ch ();

    mouse_packet_event_decoder_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // items waiting for the driver, events owed by the block
    t_byte_item pending_bytes[$];
    t_event     expected_events[$];

    // local copy of the decoder state
    logic [1:0] byte_pos;
    logic [7:0] pkt_buttons_byte;
    logic [7:0] pkt_dx;
    logic [2:0] button_state;

    // idling percentages per phase, set by the stimulus block
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;

    // long receiver hold-off, requested once, counted in the receiver process
    bit          hold_req;
    bit          hold_started;
    int unsigned hold_left;

    bit in_taken;
    int mismatch_count;

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // decode one accepted item into the events it must produce
    task automatic decode_mouse_byte(input logic [7:0] status, input logic [7:0] data);
        t_event     ev;
        logic [2:0] new_buttons;
        int         produced;
        produced = 0;
        // items without the aux data bit are dropped without a trace
        if (!status[AUX_BIT])
            return;
        if (byte_pos == 2'd2) begin
            byte_pos    = 2'd0;
            new_buttons = pkt_buttons_byte[2:0];
            // move only when there is motion; y comes out negated, -128 stays -128
            if (pkt_dx != 8'd0 || data != 8'd0) begin
                ev.kind   = KIND_MOVE;
                ev.dx     = pkt_dx;
                ev.dy     = 8'd0 - data;
                ev.button = 2'd0;
                ev.last   = 1'b0;
                expected_events.push_back(ev);
                produced++;
            end
            // buttons 1..3 in order, one event per changed bit
            for (int b = 0; b < BUTTON_COUNT; b++) begin
                if (new_buttons[b] != button_state[b]) begin
                    ev.kind   = button_state[b] ? KIND_UP : KIND_DOWN;
                    ev.dx     = 8'd0;
                    ev.dy     = 8'd0;
                    ev.button = 2'(b + 1);
                    ev.last   = 1'b0;
                    expected_events.push_back(ev);
                    produced++;
                end
            end
            button_state = new_buttons;
            // an empty packet produces nothing, so no last marker either
            if (produced > 0)
                expected_events[expected_events.size() - 1].last = 1'b1;
        end else if (byte_pos == 2'd1) begin
            pkt_dx   = data;
            byte_pos = 2'd2;
        end else begin
            pkt_buttons_byte = data;
            byte_pos         = 2'd1;
        end
    endtask

    // random status byte with the aux bit set, and one with it clear
    function automatic logic [7:0] aux_status();
        return 8'($urandom_range(255)) | (8'd1 << AUX_BIT);
    endfunction

    function automatic logic [7:0] noise_status();
        return 8'($urandom_range(255)) & ~(8'd1 << AUX_BIT);
    endfunction

    task automatic push_byte(input logic [7:0] status, input logic [7:0] data,
                             input bit drain_first = 1'b0);
        t_byte_item item;
        item.status      = status;
        item.data        = data;
        item.drain_first = drain_first;
        pending_bytes.push_back(item);
    endtask

    task automatic push_packet(input logic [7:0] b0, input logic [7:0] bx,
                               input logic [7:0] by);
        push_byte(aux_status(), b0);
        push_byte(aux_status(), bx);
        push_byte(aux_status(), by);
    endtask

    // driver: new item on the falling edge once the last one was taken;
    // valid never drops while an item is still waiting to be accepted
    always @(negedge i_clk) begin
        if (i_rst_n && in_ch.valid && !in_taken) begin
            // keep offering the same item
        end else if (i_rst_n && pending_bytes.size() != 0
                     && $urandom_range(99) >= send_idle_pct
                     && !(pending_bytes[0].drain_first && expected_events.size() != 0)) begin
            in_ch.valid       <= 1'b1;
            in_ch.status_byte <= pending_bytes[0].status;
            in_ch.data_byte   <= pending_bytes[0].data;
            void'(pending_bytes.pop_front());
        end else begin
            in_ch.valid <= 1'b0;
        end
    end

    // receiver: random ready, or held low for a long stretch once
    always @(negedge i_clk) begin
        if (hold_req && !hold_started) begin
            hold_started = 1'b1;
            hold_left    = 300;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // monitor: check leaving events first, then predict from the taken item
    always @(posedge i_clk) begin
        t_event want;
        in_taken = 1'b0;
        if (i_rst_n) begin
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
                if (expected_events.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: event with none owed: got kind=%0d dx=%0d dy=%0d",
                             $time, out_ch.event_kind, out_ch.delta_x, out_ch.delta_y);
                    $display("%0t:                       btn=%0d last=%0b",
                             $time, out_ch.button_number, out_ch.last_event);
                end else begin
                    want = expected_events.pop_front();
                    if (out_ch.event_kind !== want.kind || out_ch.delta_x !== want.dx
                        || out_ch.delta_y !== want.dy || out_ch.button_number !== want.button
                        || out_ch.last_event !== want.last) begin
                        mismatch_count++;
                        $display("%0t: expected kind=%0d dx=%0d dy=%0d btn=%0d last=%0b",
                                 $time, want.kind, $signed(want.dx), $signed(want.dy),
                                 want.button, want.last);
                        $display("%0t: actual   kind=%0d dx=%0d dy=%0d btn=%0d last=%0b",
                                 $time, out_ch.event_kind, out_ch.delta_x, out_ch.delta_y,
                                 out_ch.button_number, out_ch.last_event);
                    end
                end
            end
            if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
                in_taken = 1'b1;
                decode_mouse_byte(in_ch.status_byte, in_ch.data_byte);
            end
        end
    end

    // stimulus: reset, directed packets, then three random phases
    initial begin
        int unsigned n_packets;
        i_clk             = 1'b0;
        i_rst_n           = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.status_byte = 8'd0;
        in_ch.data_byte   = 8'd0;
        out_ch.ready      = 1'b0;
        byte_pos          = 2'd0;
        pkt_buttons_byte  = 8'd0;
        pkt_dx            = 8'd0;
        button_state      = 3'd0;
        hold_req          = 1'b0;
        hold_started      = 1'b0;
        hold_left         = 0;
        in_taken          = 1'b0;
        mismatch_count    = 0;
        send_idle_pct     = 8;
        recv_idle_pct     = 82;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int phase = 0; phase < 3; phase++) begin
            // idling pattern: receiver mostly stalled, then sender, then neither
            case (phase)
                0: begin
                    send_idle_pct = 8;
                    recv_idle_pct = 82;
                end
                1: begin
                    send_idle_pct = 82;
                    recv_idle_pct = 8;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase

            if (phase == 0) begin
                // ignored item with every other status bit clear
                push_byte(8'h00, 8'hff);
                // max positive x, y of -128 wraps, all three buttons go down
                push_packet(8'h07, 8'h7f, 8'h80);
                // upper bits of byte 0 ignored: all three buttons go up, no move
                push_byte(8'hff, 8'hf8);
                push_byte(8'h20, 8'h00);
                push_byte(8'h3f, 8'h00);
                // empty packet: nothing at all
                push_packet(8'h00, 8'h00, 8'h00);
                // x of -128, y of 1, button 2 down
                push_byte(8'h20, 8'h02);
                push_byte(8'ha0, 8'h80);
                // noise with all bits but the aux bit, in the middle of a packet
                push_byte(8'hdf, 8'h55);
                push_byte(8'h60, 8'h01);
                // sign bits set, buttons unchanged: a move alone
                push_packet(8'hc2, 8'hff, 8'h00);
                // y of -1, down 1, up 2, down 3
                push_packet(8'h05, 8'h00, 8'hff);
            end

            // block fills up behind a long receiver stall while items keep coming
            if (phase == 2)
                hold_req = 1'b1;

            n_packets = 9;
            for (int k = 0; k < n_packets; k++) begin
                // now and then noise, or a stray aux byte that shifts the framing
                if ($urandom_range(7) == 0)
                    push_byte(noise_status(), 8'($urandom_range(255)));
                if ($urandom_range(11) == 0)
                    push_byte(aux_status(), 8'($urandom_range(255)));
                if (phase == 1 && k == 6) begin
                    // sender pauses until every owed event has come out
                    push_byte(aux_status(), 8'($urandom_range(255)), 1'b1);
                    push_byte(aux_status(), ($urandom_range(3) == 0) ? 8'd0
                                            : 8'($urandom_range(255)));
                    push_byte(aux_status(), 8'($urandom_range(255)));
                end else begin
                    push_packet(8'($urandom_range(255)),
                                ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom_range(255)),
                                ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom_range(255)));
                end
            end

            // wait for the phase to drain completely
            while (pending_bytes.size() != 0 || in_ch.valid || expected_events.size() != 0)
                @(posedge i_clk);
        end

        // grace period for stray events
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0 && expected_events.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
